// ----- rtl/cir_pkg.sv -----
`timescale 1ns / 1ps

package cir_pkg;

  localparam int unsigned MAX_HOST_CORES_DEF = 1024;

  localparam int HOST_CNT_W = 11;
  localparam int NCPU_W = 9;
  localparam int NCLUSTER_W = 6;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CORE_W = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_VENDOR_AMD      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_ENABLES = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOST_CPU_COUNT  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CPU_MHZ         = 8'd3;

  localparam logic [31:0] LEAF_VENDOR     = 32'h0000_0000;
  localparam logic [31:0] LEAF_FEATURES   = 32'h0000_0001;
  localparam logic [31:0] LEAF_CACHE_DESC = 32'h0000_0002;
  localparam logic [31:0] LEAF_CACHE_PARM = 32'h0000_0004;
  localparam logic [31:0] LEAF_MONITOR    = 32'h0000_0005;
  localparam logic [31:0] LEAF_EXT_FEAT   = 32'h0000_0007;
  localparam logic [31:0] LEAF_TOPOLOGY   = 32'h0000_000B;
  localparam logic [31:0] LEAF_XSAVE      = 32'h0000_000D;
  localparam logic [31:0] LEAF_TRACE      = 32'h0000_0014;
  localparam logic [31:0] LEAF_TSC        = 32'h0000_0015;
  localparam logic [31:0] LEAF_FREQ       = 32'h0000_0016;
  localparam logic [31:0] LEAF_EXT_MAX    = 32'h8000_0000;
  localparam logic [31:0] LEAF_EXT_FEATS  = 32'h8000_0001;
  localparam logic [31:0] LEAF_BRAND0     = 32'h8000_0002;
  localparam logic [31:0] LEAF_BRAND1     = 32'h8000_0003;
  localparam logic [31:0] LEAF_BRAND2     = 32'h8000_0004;
  localparam logic [31:0] LEAF_L2_CACHE   = 32'h8000_0006;
  localparam logic [31:0] LEAF_POWER      = 32'h8000_0007;
  localparam logic [31:0] LEAF_ADDR_SIZE  = 32'h8000_0008;
  localparam logic [31:0] LEAF_PERF_OPT   = 32'h8000_001A;

  localparam logic [31:0] AMD_SIG   = 32'h0087_0F1C;
  localparam logic [31:0] INTEL_SIG = 32'h0004_0661;

  localparam logic [31:0] BRAND_ROM [12] = '{
    32'h2020_2020, 32'h2020_2020, 32'h2020_2020, 32'h2020_2020,
    32'h2020_2020, 32'h2020_2020, 32'h7472_6956, 32'h206C_6175,
    32'h2D36_3878, 32'h5020_3436, 32'h6563_6F72, 32'h726F_7373
  };

  typedef struct packed {
    logic                  vendor_amd;
    logic [5:0]            feat;
    logic [15:0]           cpu_mhz;
    logic [NCPU_W-1:0]     ncpu;
    logic [NCLUSTER_W-1:0] ncluster;
  } cfg_t;

endpackage

// ----- rtl/cir_cfg.sv -----
`timescale 1ns / 1ps

module cir_cfg #(
  parameter int unsigned MAX_HOST_CORES = cir_pkg::MAX_HOST_CORES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cir_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cir_pkg::cfg_t                   cfg
);

  logic                             vendor_amd_r;
  logic [5:0]                       feat_r;
  logic [cir_pkg::HOST_CNT_W-1:0]   host_cnt_r;
  logic [15:0]                      cpu_mhz_r;
  logic [cir_pkg::NCPU_W-1:0]       ncpu;
  logic [cir_pkg::NCLUSTER_W-1:0]   ncluster;
  logic [cir_pkg::HOST_CNT_W-1:0]   cnt_nz, cnt_cl, cnt_m1;

  always_comb begin
    cnt_nz = (host_cnt_r == '0) ? cir_pkg::HOST_CNT_W'(1) : host_cnt_r;
    if (32'(cnt_nz) > MAX_HOST_CORES) begin
      cnt_cl = MAX_HOST_CORES[cir_pkg::HOST_CNT_W-1:0];
    end else begin
      cnt_cl = cnt_nz;
    end
    cnt_m1 = cnt_cl - cir_pkg::HOST_CNT_W'(1);
    if (vendor_amd_r) begin
      ncpu = {1'b0, cnt_m1[7:0]} + cir_pkg::NCPU_W'(1);
      ncluster = cir_pkg::NCLUSTER_W'({3'b0, cnt_m1[10:8]} + 4'd1);
    end else begin
      ncpu = (cnt_cl > cir_pkg::HOST_CNT_W'(64)) ? cir_pkg::NCPU_W'(64)
                                                  : cnt_cl[cir_pkg::NCPU_W-1:0];
      ncluster = cir_pkg::NCLUSTER_W'({1'b0, cnt_m1[10:6]}) + cir_pkg::NCLUSTER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vendor_amd_r <= 1'b0;
      feat_r       <= '0;
      host_cnt_r   <= cir_pkg::HOST_CNT_W'(1);
      cpu_mhz_r    <= 16'd2000;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cir_pkg::REG_VENDOR_AMD:      vendor_amd_r <= cfg_wdata[0];
          cir_pkg::REG_FEATURE_ENABLES: feat_r <= cfg_wdata[5:0];
          cir_pkg::REG_HOST_CPU_COUNT:  host_cnt_r <= cfg_wdata[cir_pkg::HOST_CNT_W-1:0];
          cir_pkg::REG_CPU_MHZ:         cpu_mhz_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign cfg.vendor_amd = vendor_amd_r;
  assign cfg.feat       = feat_r;
  assign cfg.cpu_mhz    = cpu_mhz_r;
  assign cfg.ncpu       = ncpu;
  assign cfg.ncluster   = ncluster;

endmodule

// ----- rtl/cir_resp.sv -----
`timescale 1ns / 1ps

module cir_resp (
  input  cir_pkg::cfg_t                 cfg,
  input  logic [31:0]                   leaf,
  input  logic [31:0]                   subleaf,
  input  logic [cir_pkg::CORE_W-1:0]    current_core,
  output logic [31:0]                   eax,
  output logic [31:0]                   ebx,
  output logic [31:0]                   ecx,
  output logic [31:0]                   edx
);

  logic amd, intel, avx, avx2, sse42, aes, pclmul, sha;
  logic [31:0] top;

  always_comb begin
    amd    = cfg.vendor_amd;
    intel  = ~cfg.vendor_amd;
    avx    = cfg.feat[0];
    avx2   = cfg.feat[1];
    sse42  = cfg.feat[2];
    aes    = cfg.feat[3];
    pclmul = cfg.feat[4];
    sha    = cfg.feat[5];
    top    = {cfg.ncpu[5:0] - 6'd1, 26'd0};
    eax = '0;
    ebx = '0;
    ecx = '0;
    edx = '0;
    unique case (leaf)
      cir_pkg::LEAF_VENDOR: begin
        if (amd) begin
          eax = 32'hF; ebx = 32'h6874_7541; ecx = 32'h444D_4163; edx = 32'h6974_6E65;
        end else begin
          eax = 32'h16; ebx = 32'h756E_6547; ecx = 32'h6C65_746E; edx = 32'h4965_6E69;
        end
      end
      cir_pkg::LEAF_FEATURES: begin
        eax = amd ? cir_pkg::AMD_SIG : cir_pkg::INTEL_SIG;
        ebx = 32'h800 | (amd ? 32'd0 : {10'd0, cfg.ncluster, 16'd0});
        edx = 32'h07AB_F9FF | {3'd0, intel, 28'd0};
        ecx[0] = 1'b1; ecx[1] = pclmul; ecx[2] = intel; ecx[3] = 1'b1;
        ecx[5] = intel; ecx[9] = 1'b1; ecx[12] = avx2; ecx[13] = 1'b1;
        ecx[19] = 1'b1; ecx[20] = sse42; ecx[22] = 1'b1; ecx[23] = 1'b1;
        ecx[25] = aes; ecx[26] = avx; ecx[27] = avx; ecx[28] = avx;
        ecx[29] = avx; ecx[30] = avx2;
      end
      cir_pkg::LEAF_CACHE_DESC: begin
        if (intel) begin
          eax = 32'h7603_6301; ebx = 32'h00F0_B6FF; edx = 32'h00C3_0000;
        end
      end
      cir_pkg::LEAF_CACHE_PARM: begin
        if (intel) begin
          case (subleaf)
            32'd0: begin eax = 32'h4121 | top; ebx = 32'h01C0_003F; ecx = 32'd63; end
            32'd1: begin eax = 32'h4122 | top; ebx = 32'h01C0_003F; ecx = 32'd63; end
            32'd2: begin eax = 32'h4143 | top; ebx = 32'h00C0_003F; ecx = 32'd1023; end
            32'd3: begin
              eax = 32'h3C63 | top; ebx = 32'h02C0_003F; ecx = 32'd8191; edx = 32'd6;
            end
            default: ;
          endcase
        end
      end
      cir_pkg::LEAF_MONITOR: begin
        eax = 32'h40; ebx = 32'h40; ecx = 32'd3; edx = 32'h1114_2120;
      end
      cir_pkg::LEAF_EXT_FEAT: begin
        if (subleaf == '0) begin
          ebx[0] = 1'b1; ebx[3] = avx; ebx[5] = avx2; ebx[6] = intel; ebx[7] = 1'b1;
          ebx[8] = avx2; ebx[9] = intel; ebx[10] = 1'b1; ebx[13] = intel;
          ebx[19] = avx2; ebx[23] = 1'b1; ebx[24] = 1'b1; ebx[29] = sha;
          ecx[9] = avx & aes; ecx[10] = avx2 & pclmul; ecx[22] = 1'b1;
        end
      end
      cir_pkg::LEAF_TOPOLOGY: begin
        if (intel) begin
          if (subleaf == 32'd0) begin
            ebx = 32'd1; ecx = subleaf | 32'h100;
          end else if (subleaf == 32'd1) begin
            ebx = 32'(cfg.ncpu); ecx = subleaf | 32'h200;
          end else begin
            ecx = subleaf;
          end
          edx = 32'(current_core);
        end
      end
      cir_pkg::LEAF_XSAVE: begin
        if (subleaf == 32'd0) begin
          eax = 32'd7; ebx = 32'd832; ecx = 32'd832;
        end else if (subleaf == 32'd2) begin
          eax = 32'd256; ebx = 32'd576;
        end
      end
      cir_pkg::LEAF_TRACE: begin
        if (intel) begin
          if (subleaf == 32'd0) begin
            eax = 32'd1; ebx = 32'hF; ecx = 32'h7;
          end else if (subleaf == 32'd1) begin
            eax = 32'h0249_0002; ebx = 32'h003F_3FFF;
          end
        end
      end
      cir_pkg::LEAF_TSC: begin
        if (intel) begin
          eax = 32'd2; ebx = 32'h120;
        end
      end
      cir_pkg::LEAF_FREQ: begin
        if (intel) begin
          eax = 32'(cfg.cpu_mhz); ebx = 32'(cfg.cpu_mhz); ecx = 32'd100;
        end
      end
      cir_pkg::LEAF_EXT_MAX: begin
        if (amd) begin
          eax = 32'h8000_001A; ebx = 32'h6874_7541; ecx = 32'h444D_4163; edx = 32'h6974_6E65;
        end else begin
          eax = 32'h8000_0008;
        end
      end
      cir_pkg::LEAF_EXT_FEATS: begin
        if (amd) begin
          eax = cir_pkg::AMD_SIG; ecx = 32'h167; edx = 32'h29FB_B97D;
        end else begin
          ecx = 32'h121; edx = 32'h2990_8901;
        end
      end
      cir_pkg::LEAF_BRAND0: begin
        eax = cir_pkg::BRAND_ROM[0]; ebx = cir_pkg::BRAND_ROM[1];
        ecx = cir_pkg::BRAND_ROM[2]; edx = cir_pkg::BRAND_ROM[3];
      end
      cir_pkg::LEAF_BRAND1: begin
        eax = cir_pkg::BRAND_ROM[4]; ebx = cir_pkg::BRAND_ROM[5];
        ecx = cir_pkg::BRAND_ROM[6]; edx = cir_pkg::BRAND_ROM[7];
      end
      cir_pkg::LEAF_BRAND2: begin
        eax = cir_pkg::BRAND_ROM[8]; ebx = cir_pkg::BRAND_ROM[9];
        ecx = cir_pkg::BRAND_ROM[10]; edx = cir_pkg::BRAND_ROM[11];
      end
      cir_pkg::LEAF_L2_CACHE: ecx = 32'h0100_6040;
      cir_pkg::LEAF_POWER: begin
        if (amd) edx = 32'h100;
      end
      cir_pkg::LEAF_ADDR_SIZE: begin
        if (amd) ecx = 32'(cfg.ncpu) - 32'd1;
        else eax = 32'h0000_302E;
      end
      cir_pkg::LEAF_PERF_OPT: begin
        if (amd) eax = 32'd3;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/cpu_identification_responder.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_ready    in_leaf, in_subleaf, in_current_core
// out_      response   out_valid / out_ready  out_eax_out .. out_edx_out
// cfg_      write      cfg_we                 cfg_index, cfg_wdata
// Each request is decoded combinationally and its response appears on the cycle after it
// is accepted; one request is taken every cycle while the output register drains.
// A stalled response holds the output register and drops in_ready until it is taken.
// Reset clears the output valid and loads the configuration defaults; a configuration
// write takes effect for requests accepted from the next cycle on.

module cpu_identification_responder #(
  parameter int unsigned MAX_HOST_CORES = cir_pkg::MAX_HOST_CORES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     in_leaf,
  input  logic [31:0]                     in_subleaf,
  input  logic [cir_pkg::CORE_W-1:0]      in_current_core,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_eax_out,
  output logic [31:0]                     out_ebx_out,
  output logic [31:0]                     out_ecx_out,
  output logic [31:0]                     out_edx_out,
  input  logic                            cfg_we,
  input  logic [cir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cir_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  cir_pkg::cfg_t cfg;
  logic [31:0] eax, ebx, ecx, edx;
  logic [31:0] eax_r, ebx_r, ecx_r, edx_r;
  logic        out_valid_r;

  cir_cfg #(.MAX_HOST_CORES(MAX_HOST_CORES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cir_resp u_resp (
    .cfg          (cfg),
    .leaf         (in_leaf),
    .subleaf      (in_subleaf),
    .current_core (in_current_core),
    .eax          (eax),
    .ebx          (ebx),
    .ecx          (ecx),
    .edx          (edx)
  );

  assign in_ready = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      eax_r <= eax;
      ebx_r <= ebx;
      ecx_r <= ecx;
      edx_r <= edx;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_eax_out = eax_r;
  assign out_ebx_out = ebx_r;
  assign out_ecx_out = ecx_r;
  assign out_edx_out = edx_r;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import cir_pkg::*;

  typedef struct packed {
    logic [31:0]       leaf;
    logic [31:0]       subleaf;
    logic [CORE_W-1:0] core;
  } query_t;

  typedef struct packed {
    logic [31:0] eax;
    logic [31:0] ebx;
    logic [31:0] ecx;
    logic [31:0] edx;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_leaf = '0;
  logic [31:0] in_subleaf = '0;
  logic [CORE_W-1:0] in_current_core = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_eax_out, out_ebx_out, out_ecx_out, out_edx_out;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cpu_identification_responder i_dut (.*);

  always #2 clk = ~clk;

  logic        mdl_amd = 1'b0;
  logic [5:0]  mdl_feat = '0;
  logic [10:0] mdl_hosts = 11'd1;
  logic [15:0] mdl_mhz = 16'd2000;

  query_t  pending_q[$];
  answer_t answers_q[$];
  int errors = 0;
  int n_answers = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit hold_sender = 1'b0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] brand_word(int idx);
    byte unsigned bytes[48];
    string txt;
    txt = "Virtual x86-64 Processor";
    foreach (bytes[i]) bytes[i] = 8'h20;
    for (int i = 0; i < txt.len(); i++) bytes[48 - txt.len() + i] = txt[i];
    return {bytes[4*idx+3], bytes[4*idx+2], bytes[4*idx+1], bytes[4*idx]};
  endfunction

  function automatic answer_t cpuid_answer(query_t q);
    answer_t r;
    int unsigned ncpu, nclus;
    logic intel, avx, avx2, sse, aes, pcl, sha;
    logic [31:0] amd_sig, top;
    int unsigned base;
    r = '0;
    intel = ~mdl_amd;
    {sha, pcl, aes, sse, avx2, avx} = mdl_feat;
    amd_sig = 32'h0087_0F1C;
    ncpu = mdl_hosts;
    nclus = 1;
    if (ncpu == 0) ncpu = 1;
    if (ncpu > 1024) ncpu = 1024;
    if (mdl_amd) begin
      while (ncpu > 256) begin nclus++; ncpu -= 256; end
    end else begin
      while (ncpu > 64) begin
        nclus++;
        if (ncpu >= 128) ncpu -= 64; else ncpu = 64;
      end
    end
    case (q.leaf)
      LEAF_VENDOR:
        if (mdl_amd) r = '{32'hF, 32'h68747541, 32'h444D4163, 32'h69746E65};
        else r = '{32'h16, 32'h756E6547, 32'h6C65746E, 32'h49656E69};
      LEAF_FEATURES: begin
        r.eax = mdl_amd ? amd_sig : 32'h0004_0661;
        r.ebx = (32'd8 << 8) | ((mdl_amd ? 32'd0 : 32'(nclus)) << 16);
        r.edx = 32'h1FF | (1 << 11) | (1 << 12) | (1 << 13) | (1 << 14) | (1 << 15)
              | (1 << 16) | (1 << 17) | (1 << 19) | (1 << 21) | (1 << 23) | (1 << 24)
              | (1 << 25) | (1 << 26) | (32'(intel) << 28);
        r.ecx = 32'h1 | (32'(pcl) << 1) | (32'(intel) << 2) | (1 << 3) | (32'(intel) << 5)
              | (1 << 9) | (32'(avx2) << 12) | (1 << 13) | (1 << 19) | (32'(sse) << 20)
              | (1 << 22) | (1 << 23) | (32'(aes) << 25) | (32'(avx) << 26)
              | (32'(avx) << 27) | (32'(avx) << 28) | (32'(avx) << 29)
              | (32'(avx2) << 30);
      end
      LEAF_CACHE_DESC:
        if (!mdl_amd) begin
          r.eax = 32'h76036301; r.ebx = 32'h00F0B6FF; r.edx = 32'h00C30000;
        end
      LEAF_CACHE_PARM:
        if (!mdl_amd) begin
          top = (ncpu - 1) << 26;
          case (q.subleaf)
            0: r = '{32'h4121 | top, 32'h01C0003F, 32'd63, 32'd0};
            1: r = '{32'h4122 | top, 32'h01C0003F, 32'd63, 32'd0};
            2: r = '{32'h4143 | top, 32'h00C0003F, 32'd1023, 32'd0};
            3: r = '{32'h3C63 | top, 32'h02C0003F, 32'd8191, 32'd6};
            default: ;
          endcase
        end
      LEAF_MONITOR: r = '{32'h40, 32'h40, 32'd3, 32'h11142120};
      LEAF_EXT_FEAT:
        if (q.subleaf == 0) begin
          r.ebx = 32'h1 | (32'(avx) << 3) | (32'(avx2) << 5) | (32'(intel) << 6) | (1 << 7)
                | (32'(avx2) << 8) | (32'(intel) << 9) | (1 << 10) | (32'(intel) << 13)
                | (32'(avx2) << 19) | (1 << 23) | (1 << 24) | (32'(sha) << 29);
          r.ecx = (32'(avx & aes) << 9) | (32'(avx2 & pcl) << 10) | (1 << 22);
        end
      LEAF_TOPOLOGY:
        if (!mdl_amd) begin
          r.ebx = (q.subleaf == 0) ? 32'd1 : ((q.subleaf == 1) ? 32'(ncpu) : 32'd0);
          r.ecx = q.subleaf | ((q.subleaf == 0) ? 32'h100 :
                               ((q.subleaf == 1) ? 32'h200 : 32'h0));
          r.edx = 32'(q.core);
        end
      LEAF_XSAVE:
        if (q.subleaf == 0) r = '{32'd7, 32'd832, 32'd832, 32'd0};
        else if (q.subleaf == 2) r = '{32'd256, 32'd576, 32'd0, 32'd0};
      LEAF_TRACE:
        if (!mdl_amd) begin
          if (q.subleaf == 0) r = '{32'd1, 32'hF, 32'h7, 32'd0};
          else if (q.subleaf == 1) r = '{32'h02490002, 32'h003F3FFF, 32'd0, 32'd0};
        end
      LEAF_TSC: if (!mdl_amd) r = '{32'd2, 32'h120, 32'd0, 32'd0};
      LEAF_FREQ: if (!mdl_amd) r = '{32'(mdl_mhz), 32'(mdl_mhz), 32'd100, 32'd0};
      LEAF_EXT_MAX:
        if (mdl_amd) r = '{32'h8000001A, 32'h68747541, 32'h444D4163, 32'h69746E65};
        else r.eax = 32'h80000008;
      LEAF_EXT_FEATS:
        if (mdl_amd) begin
          r.eax = amd_sig;
          r.ecx = 32'h167;
          r.edx = 32'h1 | (1 << 2) | (1 << 3) | (1 << 4) | (1 << 5) | (1 << 6) | (1 << 8)
                | (1 << 11) | (1 << 12) | (1 << 13) | (1 << 15) | (1 << 16) | (1 << 17)
                | (1 << 19) | (1 << 20) | (1 << 21) | (1 << 22) | (1 << 23) | (1 << 24)
                | (1 << 27) | (1 << 29);
        end else begin
          r.ecx = 32'h121;
          r.edx = 32'h1 | (1 << 8) | (1 << 11) | (1 << 15) | (1 << 20) | (1 << 23)
                | (1 << 24) | (1 << 27) | (1 << 29);
        end
      LEAF_BRAND0, LEAF_BRAND1, LEAF_BRAND2: begin
        base = (q.leaf - LEAF_BRAND0) * 4;
        r = '{brand_word(base), brand_word(base + 1), brand_word(base + 2),
              brand_word(base + 3)};
      end
      LEAF_L2_CACHE: r.ecx = 32'd64 | (32'd6 << 12) | (32'd256 << 16);
      LEAF_POWER: if (mdl_amd) r.edx = 32'h100;
      LEAF_ADDR_SIZE:
        if (mdl_amd) r.ecx = ncpu - 1;
        else r.eax = 32'h302E;
      LEAF_PERF_OPT: if (mdl_amd) r.eax = 32'd3;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      answers_q.push_back(cpuid_answer('{in_leaf, in_subleaf, in_current_core}));
    end
    if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_sender && rst_n) begin
        query_t q;
        q = pending_q.pop_front();
        in_valid <= 1'b1;
        in_leaf <= q.leaf;
        in_subleaf <= q.subleaf;
        in_current_core <= q.core;
        gap_left <= rand_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      answer_t e;
      n_answers++;
      if (answers_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        e = answers_q.pop_front();
        if (out_eax_out !== e.eax) begin
          $error("eax_out expected %h actual %h", e.eax, out_eax_out); errors++;
        end
        if (out_ebx_out !== e.ebx) begin
          $error("ebx_out expected %h actual %h", e.ebx, out_ebx_out); errors++;
        end
        if (out_ecx_out !== e.ecx) begin
          $error("ecx_out expected %h actual %h", e.ecx, out_ecx_out); errors++;
        end
        if (out_edx_out !== e.edx) begin
          $error("edx_out expected %h actual %h", e.edx, out_edx_out); errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left <= rand_gap();
    end
  end

  localparam logic [31:0] KNOWN_LEAVES [20] = '{
    LEAF_VENDOR, LEAF_FEATURES, LEAF_CACHE_DESC, LEAF_CACHE_PARM, LEAF_MONITOR,
    LEAF_EXT_FEAT, LEAF_TOPOLOGY, LEAF_XSAVE, LEAF_TRACE, LEAF_TSC, LEAF_FREQ,
    LEAF_EXT_MAX, LEAF_EXT_FEATS, LEAF_BRAND0, LEAF_BRAND1, LEAF_BRAND2,
    LEAF_L2_CACHE, LEAF_POWER, LEAF_ADDR_SIZE, LEAF_PERF_OPT
  };

  task automatic drain();
    while (pending_q.size() > 0 || answers_q.size() > 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VENDOR_AMD: mdl_amd = val[0];
      REG_FEATURE_ENABLES: mdl_feat = val[5:0];
      REG_HOST_CPU_COUNT: mdl_hosts = val[10:0];
      REG_CPU_MHZ: mdl_mhz = val;
      default: ;
    endcase
    repeat (3) @(posedge clk);
  endtask

  function automatic query_t random_query();
    query_t q;
    int r;
    r = $urandom_range(0, 99);
    q.core = CORE_W'($urandom());
    q.subleaf = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4);
    if (r < 80) q.leaf = KNOWN_LEAVES[$urandom_range(0, 19)];
    else if (r < 90) q.leaf = $urandom_range(0, 32'h20);
    else if (r < 95) q.leaf = 32'h8000_0000 + $urandom_range(0, 32'h20);
    else q.leaf = $urandom();
    return q;
  endfunction

  initial begin
    int unsigned hosts_set [8] = '{0, 1, 64, 65, 127, 257, 1024, 2047};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (KNOWN_LEAVES[i]) pending_q.push_back('{KNOWN_LEAVES[i], 32'd0, 10'd0});
    pending_q.push_back('{LEAF_TOPOLOGY, 32'd1, 10'h3FF});
    pending_q.push_back('{LEAF_TOPOLOGY, 32'hFFFF_FFFF, 10'h155});
    pending_q.push_back('{LEAF_CACHE_PARM, 32'd3, 10'd0});
    pending_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF});
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_VENDOR_AMD, CFG_DATA_W'(ph[0]));
      write_reg(REG_FEATURE_ENABLES,
                (ph == 0) ? 16'd0 : (ph == 7) ? 16'h3F : CFG_DATA_W'($urandom()));
      write_reg(REG_HOST_CPU_COUNT, CFG_DATA_W'(hosts_set[ph]));
      write_reg(REG_CPU_MHZ,
                (ph == 2) ? 16'hFFFF : (ph == 3) ? 16'd0 : CFG_DATA_W'($urandom()));
      for (int k = 0; k < 128; k++) pending_q.push_back(random_query());
      if (ph == 4) begin
        while (pending_q.size() > 64) @(posedge clk);
        hold_sender = 1'b1;
        while (answers_q.size() > 0 || in_valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end
    repeat (10) @(posedge clk);
    $display("Covered %0d responses over 8 register settings, both vendors.", n_answers);
    if (errors == 0 && answers_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
